[src/msdd_pkg.sv]
package msdd_pkg;

    // Field widths of the request, result and register channels
    localparam int unsigned MOTOR_W      = 2;
    localparam int unsigned VEL_W        = 24;
    localparam int unsigned ELAPSED_W    = 21;
    localparam int unsigned DT_W         = ELAPSED_W - 1;
    localparam int unsigned TIMER_W      = 32;
    localparam int unsigned DEBOUNCE_W   = 26;
    localparam int unsigned PROP_W       = 16;
    localparam int unsigned DEADZONE_W   = 23;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 26;
    localparam int unsigned NUM_MOTORS   = 3;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(500000);
    localparam logic [PROP_W-1:0]     PROP_RST     = PROP_W'(16384);
    localparam logic [DEADZONE_W-1:0] DEADZONE_RST = DEADZONE_W'(256);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_DEBOUNCE    = 3'd0,
        CFG_TRACK_PROP        = 3'd1,
        CFG_TRACK_DEADZONE    = 3'd2,
        CFG_TRENCHER_DEBOUNCE = 3'd3,
        CFG_TRENCHER_PROP     = 3'd4,
        CFG_TRENCHER_DEADZONE = 3'd5
    } t_cfg_idx;

    // Motor codes
    localparam logic [MOTOR_W-1:0] MOTOR_LEFT     = 2'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_RIGHT    = 2'd1;
    localparam logic [MOTOR_W-1:0] MOTOR_TRENCHER = 2'd2;

    // Register file contents as one bundle
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] track_debounce_us;
        logic [PROP_W-1:0]     track_min_proportion;
        logic [DEADZONE_W-1:0] track_deadzone;
        logic [DEBOUNCE_W-1:0] trencher_debounce_us;
        logic [PROP_W-1:0]     trencher_min_proportion;
        logic [DEADZONE_W-1:0] trencher_deadzone;
    } t_cfg;

    // One registered request
    typedef struct packed {
        logic [MOTOR_W-1:0]          motor_index;
        logic signed [VEL_W-1:0]     measured_velocity;
        logic signed [VEL_W-1:0]     command_value;
        logic                        velocity_mode;
        logic                        current_limit_fault;
        logic signed [ELAPSED_W-1:0] elapsed_us;
    } t_item;

    // Limits per motor, selected for the request in flight
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_us;
        logic [PROP_W-1:0]     min_proportion;
        logic [DEADZONE_W-1:0] deadzone;
    } t_limits;

    // Saturating timer add
    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [DT_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + (TIMER_W+1)'(b);
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

endpackage

[src/msdd_if.sv]
interface msdd_in_if import msdd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [MOTOR_W-1:0]          motor_index;
    logic signed [VEL_W-1:0]     measured_velocity;
    logic signed [VEL_W-1:0]     command_value;
    logic                        velocity_mode;
    logic                        current_limit_fault;
    logic signed [ELAPSED_W-1:0] elapsed_us;

    modport source (
        output valid, motor_index, measured_velocity, command_value,
               velocity_mode, current_limit_fault, elapsed_us,
        input  ready
    );
    modport sink (
        input  valid, motor_index, measured_velocity, command_value,
               velocity_mode, current_limit_fault, elapsed_us,
        output ready
    );
endinterface

interface msdd_out_if import msdd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MOTOR_W-1:0] result_motor;
    logic               stalled;
    logic [TIMER_W-1:0] stalled_time_us;

    modport source (
        output valid, result_motor, stalled, stalled_time_us,
        input  ready
    );
    modport sink (
        input  valid, result_motor, stalled, stalled_time_us,
        output ready
    );
endinterface

interface msdd_cfg_if import msdd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/msdd_cfg.sv]
module msdd_cfg import msdd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msdd_cfg_if.sink      i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_debounce_us       <= DEBOUNCE_RST;
            r_cfg.track_min_proportion    <= PROP_RST;
            r_cfg.track_deadzone          <= DEADZONE_RST;
            r_cfg.trencher_debounce_us    <= DEBOUNCE_RST;
            r_cfg.trencher_min_proportion <= PROP_RST;
            r_cfg.trencher_deadzone       <= DEADZONE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TRACK_DEBOUNCE: begin
                    r_cfg.track_debounce_us <= i_cfg.data[DEBOUNCE_W-1:0];
                end
                CFG_TRACK_PROP: begin
                    r_cfg.track_min_proportion <= i_cfg.data[PROP_W-1:0];
                end
                CFG_TRACK_DEADZONE: begin
                    r_cfg.track_deadzone <= i_cfg.data[DEADZONE_W-1:0];
                end
                CFG_TRENCHER_DEBOUNCE: begin
                    r_cfg.trencher_debounce_us <= i_cfg.data[DEBOUNCE_W-1:0];
                end
                CFG_TRENCHER_PROP: begin
                    r_cfg.trencher_min_proportion <= i_cfg.data[PROP_W-1:0];
                end
                CFG_TRENCHER_DEADZONE: begin
                    r_cfg.trencher_deadzone <= i_cfg.data[DEADZONE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[src/msdd_cond.sv]
module msdd_cond import msdd_pkg::*; (
    input  t_item   i_item,
    input  t_limits i_limits,
    output logic    o_raw
);

    logic [VEL_W-1:0]          mag;
    logic                      outside;
    logic signed [VEL_W+16:0]  lhs;
    logic signed [VEL_W+16:0]  rhs;
    logic                      low_ratio;

    // Command magnitude against deadzone
    assign mag     = i_item.command_value[VEL_W-1] ? VEL_W'(-i_item.command_value)
                                                   : VEL_W'(i_item.command_value);
    assign outside = mag > {1'b0, i_limits.deadzone};

    // Ratio test by cross multiplication: v * 2^15 against p * c
    assign lhs = {{2{i_item.measured_velocity[VEL_W-1]}}, i_item.measured_velocity, 15'b0};
    assign rhs = $signed({1'b0, i_limits.min_proportion}) * i_item.command_value;

    always_comb begin
        if (i_item.command_value == '0) begin
            low_ratio = 1'b0;
        end else if (i_item.command_value[VEL_W-1]) begin
            low_ratio = lhs > rhs;
        end else begin
            low_ratio = lhs < rhs;
        end
    end

    assign o_raw = i_item.velocity_mode & i_item.current_limit_fault & outside & low_ratio;

endmodule

[src/msdd_state.sv]
module msdd_state import msdd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [MOTOR_W-1:0]    i_motor,
    input  logic [ELAPSED_W-1:0]  i_elapsed_us,
    input  logic                  i_raw,
    input  logic [DEBOUNCE_W-1:0] i_debounce_us,
    output logic                  o_stalled,
    output logic [TIMER_W-1:0]    o_stalled_time_us
);

    logic [TIMER_W-1:0] r_stall_timer    [NUM_MOTORS];
    logic [TIMER_W-1:0] r_recovery_timer [NUM_MOTORS];
    logic               r_stall_flag     [NUM_MOTORS];
    logic [TIMER_W-1:0] r_stall_duration [NUM_MOTORS];

    logic               motor_ok;
    logic [DT_W-1:0]    dt;
    logic [TIMER_W-1:0] debounce;
    logic [TIMER_W-1:0] cur_st;
    logic [TIMER_W-1:0] cur_rc;
    logic               cur_fl;
    logic [TIMER_W-1:0] cur_du;
    logic [TIMER_W-1:0] n_st;
    logic [TIMER_W-1:0] n_rc;
    logic               n_fl;
    logic [TIMER_W-1:0] n_du;

    assign motor_ok = i_motor <= MOTOR_TRENCHER;
    // Negative elapsed time counts as zero
    assign dt       = i_elapsed_us[ELAPSED_W-1] ? '0 : i_elapsed_us[DT_W-1:0];
    assign debounce = TIMER_W'(i_debounce_us);

    // Current state of the addressed motor
    always_comb begin
        cur_st = '0;
        cur_rc = '0;
        cur_fl = 1'b0;
        cur_du = '0;
        if (motor_ok) begin
            cur_st = r_stall_timer[i_motor];
            cur_rc = r_recovery_timer[i_motor];
            cur_fl = r_stall_flag[i_motor];
            cur_du = r_stall_duration[i_motor];
        end
    end

    // Timer and debounce update
    always_comb begin
        n_st = i_raw ? sat_add(cur_st, dt) : '0;
        n_rc = i_raw ? '0 : sat_add(cur_rc, dt);
        n_fl = cur_fl;
        n_du = cur_du;
        if (!cur_fl && n_st >= debounce) begin
            n_fl = 1'b1;
            n_du = n_st;
        end else if (cur_fl && n_rc >= debounce) begin
            n_fl = 1'b0;
            n_du = '0;
        end else if (cur_fl) begin
            n_du = sat_add(cur_du, dt);
        end
    end

    // Unknown motor code gives an empty result
    assign o_stalled         = motor_ok & n_fl;
    assign o_stalled_time_us = motor_ok ? n_du : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_stall_timer[i]    <= '0;
                r_recovery_timer[i] <= '0;
                r_stall_flag[i]     <= 1'b0;
                r_stall_duration[i] <= '0;
            end
        end else if (i_en && motor_ok) begin
            r_stall_timer[i_motor]    <= n_st;
            r_recovery_timer[i_motor] <= n_rc;
            r_stall_flag[i_motor]     <= n_fl;
            r_stall_duration[i_motor] <= n_du;
        end
    end

endmodule

[src/motor_stall_debounce_detector.sv]
// Debounced stall detector for three motors: left track, right track, trencher.
// i_in carries one control tick per request (motor, measured and commanded
// velocity, mode and fault flags, elapsed microseconds); o_out returns one
// result per request (motor, debounced stall flag, stalled time in us).
// i_cfg writes the six limit registers, one index and value per request; it
// is always ready and should only be written while the block is idle.
// A request taken passes through the input register and then the result register
// on its way to o_out. Throughput: one request per cycle while the receiver does not stall;
// the per-motor timers are updated when a request leaves the input
// register, so a request for the same motor right behind sees the updated timers.
// A stalled receiver holds the result register; the input register still
// takes one more request, after which i_in.ready drops until o_out drains.
// Reset (i_rst_n low, synchronous) clears all timers and stall flags,
// empties both registers and loads the register defaults.
module motor_stall_debounce_detector import msdd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msdd_in_if.sink     i_in,
    msdd_out_if.source  o_out,
    msdd_cfg_if.sink    i_cfg
);

    t_cfg               cfg;
    t_limits            limits;
    t_item              r_item;
    logic               r_in_valid;
    logic               r_out_valid;
    logic [MOTOR_W-1:0] r_res_motor;
    logic               r_res_stalled;
    logic [TIMER_W-1:0] r_res_time;
    logic               advance;
    logic               raw;
    logic               stalled;
    logic [TIMER_W-1:0] stalled_time;

    msdd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Handshake: move a request to the result register when it has room
    assign advance    = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | advance;

    // Limits of the motor in the input register
    always_comb begin
        if (r_item.motor_index == MOTOR_TRENCHER) begin
            limits.debounce_us    = cfg.trencher_debounce_us;
            limits.min_proportion = cfg.trencher_min_proportion;
            limits.deadzone       = cfg.trencher_deadzone;
        end else begin
            limits.debounce_us    = cfg.track_debounce_us;
            limits.min_proportion = cfg.track_min_proportion;
            limits.deadzone       = cfg.track_deadzone;
        end
    end

    msdd_cond u_cond (
        .i_item   (r_item),
        .i_limits (limits),
        .o_raw    (raw)
    );

    msdd_state u_state (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (advance),
        .i_motor           (r_item.motor_index),
        .i_elapsed_us      (r_item.elapsed_us),
        .i_raw             (raw),
        .i_debounce_us     (limits.debounce_us),
        .o_stalled         (stalled),
        .o_stalled_time_us (stalled_time)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_item.motor_index         <= i_in.motor_index;
            r_item.measured_velocity   <= i_in.measured_velocity;
            r_item.command_value       <= i_in.command_value;
            r_item.velocity_mode       <= i_in.velocity_mode;
            r_item.current_limit_fault <= i_in.current_limit_fault;
            r_item.elapsed_us          <= i_in.elapsed_us;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_res_motor   <= r_item.motor_index;
            r_res_stalled <= stalled;
            r_res_time    <= stalled_time;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_motor    = r_res_motor;
    assign o_out.stalled         = r_res_stalled;
    assign o_out.stalled_time_us = r_res_time;

endmodule

[tb/tb_motor_stall_debounce_detector.sv]
`timescale 1ns / 1ps

module tb_motor_stall_debounce_detector;
    import msdd_pkg::*;

    // One expected result of a tick request
    typedef struct {
        logic [MOTOR_W-1:0] motor;
        logic               stalled;
        logic [TIMER_W-1:0] time_us;
    } t_stall_result;

    // Tracks per-motor debounce state and the results still owed by the block
    class t_stall_scoreboard;
        t_cfg               limits;
        logic [TIMER_W-1:0] stall_timer    [NUM_MOTORS];
        logic [TIMER_W-1:0] recovery_timer [NUM_MOTORS];
        logic [TIMER_W-1:0] stall_dur      [NUM_MOTORS];
        bit                 stalled        [NUM_MOTORS];
        t_stall_result      owed[$];
        int                 errors;

        function new();
            limits.track_debounce_us       = DEBOUNCE_RST;
            limits.track_min_proportion    = PROP_RST;
            limits.track_deadzone          = DEADZONE_RST;
            limits.trencher_debounce_us    = DEBOUNCE_RST;
            limits.trencher_min_proportion = PROP_RST;
            limits.trencher_deadzone       = DEADZONE_RST;
            for (int i = 0; i < NUM_MOTORS; i++) begin
                stall_timer[i]    = '0;
                recovery_timer[i] = '0;
                stall_dur[i]      = '0;
                stalled[i]        = 1'b0;
            end
            errors = 0;
        endfunction

        // Register write; upper bits beyond a register's width are dropped
        function void write_limit(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TRACK_DEBOUNCE:    limits.track_debounce_us       = data[DEBOUNCE_W-1:0];
                CFG_TRACK_PROP:        limits.track_min_proportion    = data[PROP_W-1:0];
                CFG_TRACK_DEADZONE:    limits.track_deadzone          = data[DEADZONE_W-1:0];
                CFG_TRENCHER_DEBOUNCE: limits.trencher_debounce_us    = data[DEBOUNCE_W-1:0];
                CFG_TRENCHER_PROP:     limits.trencher_min_proportion = data[PROP_W-1:0];
                CFG_TRENCHER_DEADZONE: limits.trencher_deadzone       = data[DEADZONE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TIMER_W-1:0] add_clamped(logic [TIMER_W-1:0] a,
                                                 logic [TIMER_W-1:0] b);
            logic [TIMER_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
        endfunction

        // Accepted tick request: advance the motor's timers, queue its result
        function void note_tick(t_item it);
            t_stall_result      r;
            int                 m;
            longint             vel, cmd, el, p, dz, mag;
            logic [TIMER_W-1:0] dt, debounce;
            bit                 low_ratio, raw;

            m = it.motor_index;
            r.motor   = it.motor_index;
            r.stalled = 1'b0;
            r.time_us = '0;
            if (m < NUM_MOTORS) begin
                vel = $signed(it.measured_velocity);
                cmd = $signed(it.command_value);
                el  = $signed(it.elapsed_us);
                dt  = (el > 0) ? TIMER_W'(el) : '0;
                if (m == MOTOR_TRENCHER) begin
                    debounce = limits.trencher_debounce_us;
                    p        = limits.trencher_min_proportion;
                    dz       = limits.trencher_deadzone;
                end else begin
                    debounce = limits.track_debounce_us;
                    p        = limits.track_min_proportion;
                    dz       = limits.track_deadzone;
                end

                // ratio test by cross-multiplying, flipped for reverse commands
                mag = (cmd < 0) ? -cmd : cmd;
                if (cmd > 0)
                    low_ratio = (vel * 32768) < (p * cmd);
                else if (cmd < 0)
                    low_ratio = (vel * 32768) > (p * cmd);
                else
                    low_ratio = 1'b0;
                raw = it.velocity_mode && it.current_limit_fault && (mag > dz) && low_ratio;

                if (raw) begin
                    stall_timer[m]    = add_clamped(stall_timer[m], dt);
                    recovery_timer[m] = '0;
                end else begin
                    recovery_timer[m] = add_clamped(recovery_timer[m], dt);
                    stall_timer[m]    = '0;
                end

                if (!stalled[m] && stall_timer[m] >= debounce) begin
                    stalled[m]   = 1'b1;
                    stall_dur[m] = stall_timer[m];
                end else if (stalled[m] && recovery_timer[m] >= debounce) begin
                    stalled[m]   = 1'b0;
                    stall_dur[m] = '0;
                end else if (stalled[m]) begin
                    stall_dur[m] = add_clamped(stall_dur[m], dt);
                end
                r.stalled = stalled[m];
                r.time_us = stall_dur[m];
            end
            owed.push_back(r);
        endfunction

        // Compare a delivered result against the oldest one owed
        function void check_result(logic [MOTOR_W-1:0] motor, logic stall,
                                   logic [TIMER_W-1:0] t_us);
            t_stall_result e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: motor %0d stalled %0b time %0d",
                             motor, stall, t_us);
            end else begin
                e = owed.pop_front();
                if (motor !== e.motor || stall !== e.stalled || t_us !== e.time_us) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0b/%0d got %0d/%0b/%0d",
                                 e.motor, e.stalled, e.time_us, motor, stall, t_us);
                end
            end
        endfunction

        function int waiting();
            return owed.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;   // no idling on either side while set

    msdd_in_if  in_if();
    msdd_out_if out_if();
    msdd_cfg_if cfg_if();

    t_stall_scoreboard sb;

    motor_stall_debounce_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("motor_stall_debounce_detector regression: fail");
        $finish;
    end

    // Result side: random back-pressure, check every accepted result
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                sb.check_result(out_if.result_motor, out_if.stalled, out_if.stalled_time_us);
            out_if.ready <= steady || ($urandom_range(0, 99) >= 27);
        end
    end

    // Present one tick request, with random idle cycles ahead of it
    task automatic send_tick(input t_item it);
        while (!steady && $urandom_range(0, 99) < 27) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid               <= 1'b1;
        in_if.motor_index         <= it.motor_index;
        in_if.measured_velocity   <= it.measured_velocity;
        in_if.command_value       <= it.command_value;
        in_if.velocity_mode       <= it.velocity_mode;
        in_if.current_limit_fault <= it.current_limit_fault;
        in_if.elapsed_us          <= it.elapsed_us;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_tick(it);
    endtask

    task automatic tick(input int m, input int vel, input int cmd,
                        input bit vm, input bit flt, input int el);
        t_item it;
        it.motor_index         = MOTOR_W'(m);
        it.measured_velocity   = VEL_W'(vel);
        it.command_value       = VEL_W'(cmd);
        it.velocity_mode       = vm;
        it.current_limit_fault = flt;
        it.elapsed_us          = ELAPSED_W'(el);
        send_tick(it);
    endtask

    // Drain: stop requests, wait for every owed result, then a few more cycles
    task automatic settle();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.waiting() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_limit(idx, data);
    endtask

    // Write all six limits; dirty puts random junk above the narrow registers
    task automatic apply_limits(input int tdb, input int tp, input int tdz,
                                input int xdb, input int xp, input int xdz,
                                input bit dirty);
        logic [CFG_DATA_W-1:0] tp_d, tdz_d, xp_d, xdz_d;
        tp_d  = CFG_DATA_W'(tp);
        tdz_d = CFG_DATA_W'(tdz);
        xp_d  = CFG_DATA_W'(xp);
        xdz_d = CFG_DATA_W'(xdz);
        if (dirty) begin
            tp_d[CFG_DATA_W-1:PROP_W]      = (CFG_DATA_W-PROP_W)'($urandom);
            xp_d[CFG_DATA_W-1:PROP_W]      = (CFG_DATA_W-PROP_W)'($urandom);
            tdz_d[CFG_DATA_W-1:DEADZONE_W] = (CFG_DATA_W-DEADZONE_W)'($urandom);
            xdz_d[CFG_DATA_W-1:DEADZONE_W] = (CFG_DATA_W-DEADZONE_W)'($urandom);
        end
        write_reg(CFG_TRACK_DEBOUNCE, CFG_DATA_W'(tdb));
        write_reg(CFG_TRACK_PROP, tp_d);
        write_reg(CFG_TRACK_DEADZONE, tdz_d);
        write_reg(CFG_TRENCHER_DEBOUNCE, CFG_DATA_W'(xdb));
        write_reg(CFG_TRENCHER_PROP, xp_d);
        write_reg(CFG_TRENCHER_DEADZONE, xdz_d);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom_range(0, 200000);
        else if (r < 65)
            v = $urandom_range(0, 1000000);
        else if (r < 80)
            v = 1000000;
        else if (r < 90)
            v = -int'($urandom_range(1, 1000000));
        else
            v = 0;
        return ELAPSED_W'(v);
    endfunction

    // Tick with the command outside the deadzone and the velocity placed near
    // the ratio threshold, on the stalling side when aim is set
    function automatic t_item shape_tick(input logic [MOTOR_W-1:0] m, input bit aim);
        t_item  it;
        longint p, dz, mag, c, bound, off, v;
        if (m == MOTOR_TRENCHER) begin
            p  = sb.limits.trencher_min_proportion;
            dz = sb.limits.trencher_deadzone;
        end else begin
            p  = sb.limits.track_min_proportion;
            dz = sb.limits.track_deadzone;
        end
        if (dz >= 8388607 || $urandom_range(0, 15) == 0) begin
            c = -8388608;
        end else begin
            if ($urandom_range(0, 1))
                mag = dz + 1 + $urandom_range(0, 15);
            else
                mag = $urandom_range(int'(dz) + 1, 8388607);
            if (mag > 8388607)
                mag = 8388607;
            c = $urandom_range(0, 1) ? -mag : mag;
        end
        bound = (p * c) / 32768;
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607) : $urandom_range(0, 2);
        // low ratio lies below the bound for forward commands, above it for reverse
        if ((c > 0) == aim)
            v = bound - off;
        else
            v = bound + off;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        it.motor_index         = m;
        it.measured_velocity   = VEL_W'(v);
        it.command_value       = VEL_W'(c);
        it.velocity_mode       = aim ? ($urandom_range(0, 19) != 0) : $urandom_range(0, 1);
        it.current_limit_fault = aim ? ($urandom_range(0, 19) != 0) : $urandom_range(0, 1);
        it.elapsed_us          = pick_elapsed();
        return it;
    endfunction

    function automatic t_item noise_tick();
        t_item it;
        int    r;
        r = $urandom_range(0, 3);
        it.motor_index       = ($urandom_range(0, 3) == 0) ? MOTOR_W'(3)
                                                           : MOTOR_W'($urandom_range(0, 2));
        it.measured_velocity = VEL_W'($urandom);
        case (r)
            0:       it.command_value = '0;
            1:       it.command_value = VEL_W'(int'($urandom_range(0, 2048)) - 1024);
            default: it.command_value = VEL_W'($urandom);
        endcase
        it.velocity_mode       = $urandom_range(0, 1);
        it.current_limit_fault = $urandom_range(0, 1);
        it.elapsed_us          = pick_elapsed();
        return it;
    endfunction

    // Random ticks: each motor sticks to stalling or recovering for a while
    task automatic run_phase(input int count, input int quiet_from, input int quiet_to);
        bit    aim [NUM_MOTORS];
        int    m;
        t_item it;
        for (int i = 0; i < NUM_MOTORS; i++)
            aim[i] = $urandom_range(0, 1);
        for (int i = 0; i < count; i++) begin
            if (i == quiet_from)
                steady = 1'b1;
            if (i == quiet_to)
                steady = 1'b0;
            m = $urandom_range(0, 2);
            if ($urandom_range(0, 39) == 0)
                aim[m] = ~aim[m];
            if ($urandom_range(0, 99) < 80)
                it = shape_tick(MOTOR_W'(m), aim[m]);
            else
                it = noise_tick();
            send_tick(it);
        end
        steady = 1'b0;
    endtask

    initial begin
        sb = new();
        steady = 1'b0;
        i_rst_n                   <= 1'b0;
        in_if.valid               <= 1'b0;
        in_if.motor_index         <= '0;
        in_if.measured_velocity   <= '0;
        in_if.command_value       <= '0;
        in_if.velocity_mode       <= 1'b0;
        in_if.current_limit_fault <= 1'b0;
        in_if.elapsed_us          <= '0;
        cfg_if.valid              <= 1'b0;
        cfg_if.index              <= '0;
        cfg_if.data               <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at the reset limits
        tick(3, 0, 1000, 1, 1, 1000000);              // motor three is ignored
        tick(MOTOR_LEFT, 0, 1000, 1, 1, 499999);      // one short of debounce
        tick(MOTOR_LEFT, 0, 1000, 1, 1, 1);           // reaches debounce exactly
        tick(MOTOR_LEFT, 0, 1000, 1, 1, -1000000);    // negative time counts as zero
        tick(MOTOR_RIGHT, 8388607, -8388608, 1, 1, 1000000);
        tick(MOTOR_RIGHT, -8388608, 8388607, 1, 0, 1000000);
        tick(MOTOR_TRENCHER, 128, 257, 1, 1, 1000000); // just outside deadzone
        tick(MOTOR_TRENCHER, 128, 256, 1, 1, 600000);  // on the deadzone edge
        tick(MOTOR_LEFT, 0, 1000, 0, 1, 0);           // velocity mode off
        settle();

        // Zero deadzone and debounce on tracks, zero proportion on trencher
        apply_limits(0, 32768, 0, 500000, 0, 256, 1'b0);
        tick(MOTOR_LEFT, -100, 0, 1, 1, 10);          // zero command never stalls
        tick(MOTOR_RIGHT, 0, 0, 1, 1, -1);
        tick(MOTOR_LEFT, 1, 1, 1, 1, 5);              // ratio exactly at threshold
        tick(MOTOR_LEFT, 0, 1, 1, 1, 0);
        tick(MOTOR_LEFT, -1, -1, 1, 1, 7);            // reverse, exactly at threshold
        tick(MOTOR_LEFT, 0, -1, 1, 1, 1000000);
        tick(MOTOR_TRENCHER, -1, 5000, 1, 1, 1000000);
        tick(MOTOR_TRENCHER, 0, 5000, 1, 1, 1000000);
        tick(MOTOR_RIGHT, 8388607, 8388607, 1, 1, 300);
        tick(MOTOR_RIGHT, 8388606, 8388607, 1, 1, 300);
        tick(MOTOR_RIGHT, -8388608, -8388608, 1, 1, 300);
        settle();

        // Random phases over several limit settings
        apply_limits(500000, 16384, 256, 500000, 16384, 256, 1'b1);
        run_phase(150, -1, -1);
        settle();
        apply_limits(0, 65535, 0, 60000000, 0, 8388607, 1'b1);
        run_phase(150, -1, -1);
        settle();
        apply_limits(60000000, 0, 8388607, 1, 65535, 0, 1'b1);
        run_phase(150, -1, -1);
        settle();
        apply_limits($urandom_range(0, 3000000), $urandom_range(0, 65535),
                     $urandom_range(0, 4096), $urandom_range(0, 3000000),
                     $urandom_range(0, 65535), $urandom_range(0, 8388607), 1'b1);
        run_phase(200, 40, 170);
        settle();
        apply_limits($urandom_range(0, 1000000), $urandom_range(0, 65535),
                     $urandom_range(0, 8388607), $urandom_range(0, 1000000),
                     $urandom_range(0, 65535), $urandom_range(0, 4096), 1'b1);
        run_phase(130, -1, -1);
        settle();

        if (sb.errors == 0)
            $display("motor_stall_debounce_detector regression: pass");
        else
            $display("motor_stall_debounce_detector regression: fail");
        $finish;
    end

endmodule
